/* src/hsfd_pkg.sv */
// ============================================================================
// hsfd_pkg: shared types, constants and functions of the frame decoder
// CRC-8 step, fixed-point scaling constants and the front-to-back record.
// ============================================================================
package hsfd_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final XOR
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Byte positions within a six-byte reply
  localparam logic [2:0] PosFirst = 3'd0;
  localparam logic [2:0] PosCrcA  = 3'd2;
  localparam logic [2:0] PosAfterCrcA = 3'd3;
  localparam logic [2:0] PosHumLo = 3'd4;
  localparam logic [2:0] PosCrcB  = 3'd5;
  localparam logic [2:0] PosLast  = 3'd5;

  // Scaling: out = floor(span * raw / 65535) - offset
  localparam logic [30:0] TempSpan   = 31'd17500;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [30:0] HumSpan    = 31'd12500;
  localparam logic [14:0] HumOffset  = 15'd600;
  localparam logic [14:0] HumClip    = 15'd10600;  // offset + max
  localparam logic [13:0] HumMax     = 14'd10000;
  localparam logic [16:0] FullScale  = 17'd65535;

  // Queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic        first_ok;
    logic        second_ok;
  } hsfd_rec_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } hsfd_fifo_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 2^31: x>>16 undershoots by at most one
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return (r >= FullScale) ? q0 + 15'd1 : q0;
  endfunction

endpackage

/* src/hsfd_if.sv */
// ============================================================================
// hsfd_if: valid/ready channels of the frame decoder
// Byte input channel and decoded reply output channel.
// ============================================================================
interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic [31:0]        serial_number;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic               first_crc_ok;
  logic               second_crc_ok;
  logic               frame_ok;

  modport source (output valid, raw_temperature, raw_humidity, serial_number,
                  temperature_centi, humidity_centi, first_crc_ok, second_crc_ok,
                  frame_ok, input ready);
  modport sink   (input valid, raw_temperature, raw_humidity, serial_number,
                  temperature_centi, humidity_centi, first_crc_ok, second_crc_ok,
                  frame_ok, output ready);
endinterface

/* src/hsfd_front.sv */
// ============================================================================
// hsfd_front: byte framing and CRC check
// Tracks the byte position, runs the CRC and pushes one record per reply.
// ============================================================================
module hsfd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hsfd_in_if.sink                  in_i,
  input  hsfd_pkg::hsfd_fifo_stat_t fifo_stat_i,
  output logic                     push_o,
  output hsfd_pkg::hsfd_rec_t      push_rec_o
);

  logic [2:0] pos_q, pos_d, pos_eff;
  logic [7:0] crc_q, crc_d, crc_cur, crc_upd;
  logic       first_ok_q, first_ok_d;
  logic [7:0] byte0_q, byte1_q, byte3_q, byte4_q;
  logic       accept;

  assign in_i.ready = !fifo_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    pos_eff    = (in_i.frame_start || (pos_q > hsfd_pkg::PosLast)) ? hsfd_pkg::PosFirst : pos_q;
    crc_cur    = (pos_eff == hsfd_pkg::PosFirst) ? hsfd_pkg::CrcInit : crc_q;
    crc_upd    = hsfd_pkg::crc8_update(crc_cur, in_i.rx_byte);
    pos_d      = pos_q;
    crc_d      = crc_q;
    first_ok_d = first_ok_q;
    push_o     = 1'b0;
    if (accept) begin
      case (pos_eff)
        hsfd_pkg::PosCrcA: begin
          first_ok_d = (crc_cur == in_i.rx_byte);
          crc_d      = hsfd_pkg::CrcInit;
          pos_d      = hsfd_pkg::PosAfterCrcA;
        end
        hsfd_pkg::PosCrcB: begin
          push_o = 1'b1;
          crc_d  = hsfd_pkg::CrcInit;
          pos_d  = hsfd_pkg::PosFirst;
        end
        default: begin
          crc_d = crc_upd;
          pos_d = pos_eff + 3'd1;
        end
      endcase
    end
  end

  assign push_rec_o.raw_t     = {byte0_q, byte1_q};
  assign push_rec_o.raw_h     = {byte3_q, byte4_q};
  assign push_rec_o.first_ok  = first_ok_q;
  assign push_rec_o.second_ok = (crc_cur == in_i.rx_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= hsfd_pkg::PosFirst;
      crc_q      <= hsfd_pkg::CrcInit;
      first_ok_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      first_ok_q <= first_ok_d;
    end
  end

  // data bytes, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (pos_eff)
        3'd0:              byte0_q <= in_i.rx_byte;
        3'd1:              byte1_q <= in_i.rx_byte;
        3'd3:              byte3_q <= in_i.rx_byte;
        hsfd_pkg::PosHumLo: byte4_q <= in_i.rx_byte;
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hsfd_pkg::PosLast)
    else $error("byte position out of range");

  a_push_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (accept && pos_eff == hsfd_pkg::PosCrcB && !fifo_stat_i.full))
    else $error("record pushed outside last byte transfer");

endmodule

/* src/hsfd_fifo.sv */
// ============================================================================
// hsfd_fifo: short record queue between front and back
// Show-ahead register queue; decouples framing from conversion.
// ============================================================================
module hsfd_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  hsfd_pkg::hsfd_rec_t       push_rec_i,
  input  logic                      pop_i,
  output hsfd_pkg::hsfd_rec_t       pop_rec_o,
  output hsfd_pkg::hsfd_fifo_stat_t stat_o
);

  hsfd_pkg::hsfd_rec_t               mem_q [hsfd_pkg::FifoDepth];
  logic [hsfd_pkg::FifoAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [hsfd_pkg::FifoCw-1:0]       cnt_q;
  logic                              do_push, do_pop;

  assign stat_o.full      = (cnt_q == hsfd_pkg::FifoCw'(hsfd_pkg::FifoDepth));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign pop_rec_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_rec_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

endmodule

/* src/hsfd_back.sv */
// ============================================================================
// hsfd_back: fixed-point conversion and output register
// Stage 1 scales the raw words, stage 2 divides, offsets and clamps humidity.
// ============================================================================
module hsfd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hsfd_pkg::hsfd_fifo_stat_t fifo_stat_i,
  input  hsfd_pkg::hsfd_rec_t       rec_i,
  output logic                      pop_o,
  hsfd_out_if.source                res_o
);

  logic                s1_v_q, out_v_q;
  hsfd_pkg::hsfd_rec_t s1_rec_q, out_rec_q;
  logic [30:0]         s1_xt_q, s1_xh_q;
  logic signed [14:0]  out_t_q, t_d;
  logic [13:0]         out_h_q, h_d;
  logic [14:0]         qt, qh;
  logic                out_free, s1_ready;

  assign out_free = !out_v_q || res_o.ready;
  assign s1_ready = !s1_v_q || out_free;
  assign pop_o    = fifo_stat_i.not_empty && s1_ready;

  always_comb begin
    qt  = hsfd_pkg::div_full_scale(s1_xt_q);
    qh  = hsfd_pkg::div_full_scale(s1_xh_q);
    t_d = $signed(qt - hsfd_pkg::TempOffset);
    if (qh < hsfd_pkg::HumOffset) begin
      h_d = '0;
    end else if (qh > hsfd_pkg::HumClip) begin
      h_d = hsfd_pkg::HumMax;
    end else begin
      h_d = 14'(qh - hsfd_pkg::HumOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q  <= pop_o;
      if (out_free) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_rec_q <= rec_i;
      s1_xt_q  <= {15'd0, rec_i.raw_t} * hsfd_pkg::TempSpan;
      s1_xh_q  <= {15'd0, rec_i.raw_h} * hsfd_pkg::HumSpan;
    end
    if (s1_v_q && out_free) begin
      out_rec_q <= s1_rec_q;
      out_t_q   <= t_d;
      out_h_q   <= h_d;
    end
  end

  assign res_o.valid             = out_v_q;
  assign res_o.raw_temperature   = out_rec_q.raw_t;
  assign res_o.raw_humidity      = out_rec_q.raw_h;
  assign res_o.serial_number     = {out_rec_q.raw_t, out_rec_q.raw_h};
  assign res_o.temperature_centi = out_t_q;
  assign res_o.humidity_centi    = out_h_q;
  assign res_o.first_crc_ok      = out_rec_q.first_ok;
  assign res_o.second_crc_ok     = out_rec_q.second_ok;
  assign res_o.frame_ok          = out_rec_q.first_ok && out_rec_q.second_ok;

  a_hum_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_h_q <= hsfd_pkg::HumMax))
    else $error("humidity above full scale");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_t_q >= -15'sd4500 && out_t_q <= 15'sd13000))
    else $error("temperature out of range");

endmodule

/* src/humidity_sensor_frame_decoder.sv */
// ============================================================================
// humidity_sensor_frame_decoder: six-byte sensor reply decoder
// Checks both CRC-8 bytes of a reply and converts its words to centi units.
// ============================================================================
// Usage:
//   in_i  carries one reply byte per transfer (rx_byte) plus frame_start,
//         which forces that byte to be byte 0 of a new reply. After byte 5
//         the position wraps to 0 by itself.
//   res_o carries one result per completed reply: both raw words, their
//         concatenation as serial number, temperature and humidity in
//         hundredths, and the two CRC flags plus frame_ok.
// Throughput: one byte per cycle while the queue has room. The CRC is eight
//   unrolled XOR steps in the front; the back takes one record per cycle
//   while res_o is ready, in a two-stage multiply / divide-by-65535 pipeline.
// Path: the transfer of byte 5 writes its record into the queue, then the
//   scaling multiply fills stage 1, then divide and clamp fill the output
//   register.
// Stall: while res_o is held off, results wait in the back stages and the
//   two-entry queue; in_i drops ready only when that queue is full.
// Reset: position returns to byte 0, the CRC to 0xFF, all stages empty.
// ============================================================================
module humidity_sensor_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsfd_in_if.sink    in_i,
  hsfd_out_if.source res_o
);

  // front -> queue
  logic                      push;
  hsfd_pkg::hsfd_rec_t       push_rec;
  // queue -> back
  logic                      pop;
  hsfd_pkg::hsfd_rec_t       pop_rec;
  hsfd_pkg::hsfd_fifo_stat_t fifo_stat;

  // Framing, CRC check and byte capture
  hsfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_rec_o  (push_rec)
  );

  // Record queue decoupling the two halves
  hsfd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .stat_o     (fifo_stat)
  );

  // Scaling pipeline and output register
  hsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench: self-checking bench for humidity_sensor_frame_decoder
// Feeds reply bytes over the byte channel with random gaps. A local decoder
// model predicts every result. The result channel is stalled at random and
// each result is compared field by field with the oldest prediction.
// ============================================================================
module testbench;

  localparam int unsigned ItemTarget = 950;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainWait  = 20;    // margin for a stray late result

  // One byte transfer on the input channel. hold_for_drain keeps the byte back
  // until every predicted result has come out of the block.
  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       hold_for_drain;
  } reply_byte_t;

  typedef struct {
    logic [15:0]        raw_t;
    logic [15:0]        raw_h;
    logic [31:0]        serial;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               first_ok;
    logic               second_ok;
    logic               both_ok;
  } decoded_reply_t;

  logic clk_i;
  logic rst_ni;

  hsfd_in_if  in_ch ();
  hsfd_out_if res_ch ();

  humidity_sensor_frame_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  reply_byte_t    byte_feed[$];     // bytes still to be sent
  decoded_reply_t decoded_q[$];     // predicted results, oldest first

  int unsigned cycles;
  int unsigned errors;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned n_items;

  // Decoder model state
  logic [2:0] pos_q;
  logic [7:0] word_bytes [5];
  logic [7:0] crc_q;
  logic       first_ok_q;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.rx_byte        = 8'h00;
    in_ch.frame_start    = 1'b0;
    res_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Cycle counter doubles as the run watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Bit-serial CRC-8, MSB first: feedback is the top CRC bit xor the data bit.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? hsfd_pkg::CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [15:0] w);
    return crc8_byte(crc8_byte(hsfd_pkg::CrcInit, w[15:8]), w[7:0]);
  endfunction

  // Idle length for either side. No gaps while cycles % 512 is below 128 (the first
  // quarter of each window); otherwise mostly short gaps and the odd long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (cycles % 512 < 128) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start, input logic hold);
    reply_byte_t it;
    it.rx_byte        = b;
    it.frame_start    = start;
    it.hold_for_drain = hold;
    byte_feed.push_back(it);
    n_items++;
  endtask

  // Full six-byte reply; a corrupt flag flips one random bit of that CRC byte.
  task automatic push_reply(input logic [15:0] wa, input logic [15:0] wb, input logic start,
                            input logic bad_a, input logic bad_b, input logic hold);
    logic [7:0] ca, cb;
    ca = crc8_word(wa) ^ (bad_a ? (8'h01 << $urandom_range(0, 7)) : 8'h00);
    cb = crc8_word(wb) ^ (bad_b ? (8'h01 << $urandom_range(0, 7)) : 8'h00);
    push_byte(wa[15:8], start, hold);
    push_byte(wa[7:0], 1'b0, 1'b0);
    push_byte(ca, 1'b0, 1'b0);
    push_byte(wb[15:8], 1'b0, 1'b0);
    push_byte(wb[7:0], 1'b0, 1'b0);
    push_byte(cb, 1'b0, 1'b0);
  endtask

  // Words biased toward the scaling extremes.
  function automatic logic [15:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Decoder model: advance by one accepted byte, queue a result on byte 5.
  // --------------------------------------------------------------------------
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]     p;
    decoded_reply_t d;
    int             t_c, h_c;
    p = pos_q;
    // frame_start (or an impossible position) restarts at byte 0
    if (start || p > hsfd_pkg::PosLast) p = hsfd_pkg::PosFirst;
    if (p == hsfd_pkg::PosFirst) crc_q = hsfd_pkg::CrcInit;

    if (p == hsfd_pkg::PosCrcA) begin
      first_ok_q = (crc_q == b);
      crc_q      = hsfd_pkg::CrcInit;
      pos_q      = hsfd_pkg::PosAfterCrcA;
    end else if (p != hsfd_pkg::PosCrcB) begin
      word_bytes[p] = b;
      crc_q         = crc8_byte(crc_q, b);
      pos_q         = p + 3'd1;
    end else begin
      d.raw_t      = {word_bytes[0], word_bytes[1]};
      d.raw_h      = {word_bytes[3], word_bytes[4]};
      d.serial     = {d.raw_t, d.raw_h};
      t_c          = -4500 + (17500 * int'(d.raw_t)) / 65535;
      h_c          = -600 + (12500 * int'(d.raw_h)) / 65535;
      if (h_c < 0) h_c = 0;
      if (h_c > 10000) h_c = 10000;
      d.temp_centi = t_c[14:0];
      d.hum_centi  = h_c[13:0];
      d.first_ok   = first_ok_q;
      d.second_ok  = (crc_q == b);
      d.both_ok    = d.first_ok & d.second_ok;
      decoded_q.push_back(d);
      pos_q = hsfd_pkg::PosFirst;
      crc_q = hsfd_pkg::CrcInit;
    end
  endtask

  // --------------------------------------------------------------------------
  // Byte driver. A byte stays on the channel until its transfer; the next one
  // (or an idle cycle) is set up in the same step.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    reply_byte_t nxt;
    logic        drive;
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.rx_byte     <= 8'h00;
      in_ch.frame_start <= 1'b0;
      gap_left          = 0;
      pos_q             = hsfd_pkg::PosFirst;
      crc_q             = hsfd_pkg::CrcInit;
      first_ok_q        = 1'b0;
      foreach (word_bytes[i]) word_bytes[i] = 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready)
        decode_byte(in_ch.rx_byte, in_ch.frame_start);
      if (!in_ch.valid || in_ch.ready) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_feed.size() > 0 &&
                     !(byte_feed[0].hold_for_drain && decoded_q.size() > 0)) begin
          nxt      = byte_feed.pop_front();
          drive    = 1'b1;
          gap_left = idle_len();
        end
        in_ch.valid <= drive;
        if (drive) begin
          in_ch.rx_byte     <= nxt.rx_byte;
          in_ch.frame_start <= nxt.frame_start;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor with random back-pressure.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    decoded_reply_t want;
    logic           rdy;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, serial", res_ch.serial_number, 32'h0);
        end else begin
          want = decoded_q.pop_front();
          if (res_ch.raw_temperature !== want.raw_t)
            report_mismatch("raw_temperature", res_ch.raw_temperature, want.raw_t);
          if (res_ch.raw_humidity !== want.raw_h)
            report_mismatch("raw_humidity", res_ch.raw_humidity, want.raw_h);
          if (res_ch.serial_number !== want.serial)
            report_mismatch("serial_number", res_ch.serial_number, want.serial);
          if (res_ch.temperature_centi !== want.temp_centi)
            report_mismatch("temperature_centi", res_ch.temperature_centi, want.temp_centi);
          if (res_ch.humidity_centi !== want.hum_centi)
            report_mismatch("humidity_centi", res_ch.humidity_centi, want.hum_centi);
          if (res_ch.first_crc_ok !== want.first_ok)
            report_mismatch("first_crc_ok", res_ch.first_crc_ok, want.first_ok);
          if (res_ch.second_crc_ok !== want.second_ok)
            report_mismatch("second_crc_ok", res_ch.second_crc_ok, want.second_ok);
          if (res_ch.frame_ok !== want.both_ok)
            report_mismatch("frame_ok", res_ch.frame_ok, want.both_ok);
        end
      end
      // hold ready low for the stall count, then one ready cycle and a new count
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy        = 1'b1;
        stall_left = idle_len();
      end
      res_ch.ready <= rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned kind, len, n_replies;
    logic        need_start;

    // Directed: scaling extremes (temperature -4500 / 13000, humidity clamped
    // low and high), back-to-back replies without frame_start, a reply
    // abandoned after three bytes, and a first-CRC failure.
    push_reply(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
    push_reply(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_reply(16'h6666, 16'hBEEF, 1'b1, 1'b1, 1'b0, 1'b0);

    // Random: mostly well-formed replies with random content and occasional
    // CRC corruption, some abandoned replies and some pure noise.
    need_start = 1'b0;
    n_replies  = 0;
    while (n_items < ItemTarget) begin
      n_replies++;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        push_reply(pick_word(), pick_word(), need_start | 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                   n_replies % 40 == 1);
        need_start = 1'b0;
      end else if (kind < 90) begin
        len = $urandom_range(1, 5);
        push_byte(8'($urandom), need_start | 1'($urandom_range(0, 1)), 1'b0);
        for (int i = 1; i < len; i++) push_byte(8'($urandom), 1'b0, 1'b0);
        need_start = 1'b1;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        need_start = 1'b1;
      end
    end

    // Wait for the feed to empty, the results to drain, then a few more cycles
    // in case a stray result is still in the pipeline.
    @(posedge rst_ni);
    while (byte_feed.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (decoded_q.size() != 0)
      report_mismatch("results missing", 32'h0, decoded_q.size());

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
